>>> hw/rtl/bht_pkg.sv
`timescale 1ns / 1ps
package bht_pkg;
    localparam int INDEX_BITS = 10;
    localparam int WAYS = 4;
    localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int BUCKETS = 1 << INDEX_BITS;
    localparam int AGE_PENALTY_LSH = 1;
    // replacement priority width: 8-bit depth minus the shifted 8-bit age distance
    localparam int PRIO_W = AGE_PENALTY_LSH + 9;
    localparam int KEY_W = 64;

    typedef enum logic [1:0] {
        OP_PROBE = 2'd0,
        OP_STORE = 2'd1,
        OP_AGE   = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef struct packed {
        logic [7:0]  age;
        logic [1:0]  bound;
        logic [7:0]  depth;
        logic [15:0] score;
        logic [15:0] move;
    } payload_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        payload_t         pl;
    } entry_t;

    // classified command passed from front to back
    typedef struct packed {
        op_t                   op;
        logic [KEY_W-1:0]      key;
        logic [INDEX_BITS-1:0] index;
        logic [15:0]           move;
        logic [15:0]           score;
        logic [7:0]            depth;
        logic [1:0]            bound;
    } cmd_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] move;
        logic [15:0] score;
        logic [7:0]  depth;
        logic [1:0]  bound;
        logic [7:0]  age;
    } result_t;
endpackage

>>> hw/rtl/bucketed_hash_table_with_aging_unit.sv
`timescale 1ns / 1ps
// set-associative position table with age-based replacement
// s_axis: one word per operation; tdata holds lookup_key, move_in, score_in,
//   depth_in, bound_in; tuser holds the op (probe, store, age step, clear)
// m_axis: exactly one result word per operation; tdata holds hit, move_out,
//   score_out, depth_out, bound_out, age_out (all zero on a miss or non-probe)
// path: a word passes a two-entry queue; an idle back end takes it from the
//   queue and reads the bucket row on that edge, then compares all ways and
//   writes back on the next edge, where the result is registered and
//   m_axis_tvalid rises
// flow: one operation in the back end at a time; each word passes take,
//   compare and result handshake before the next word is taken
// clear walks every bucket, one row per cycle, and its result shows once the
//   sweep of all 2^INDEX_BITS (1024) rows is done
// reset: the same sweep zeroes the table before the first operation is
//   executed; the front queue still takes up to two words
// stall: while m_axis_tready is low the result holds and the back end waits;
//   the front queue fills and then drops s_axis_tready
module bucketed_hash_table_with_aging_unit
    import bht_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // lookup_key[63:0], move_in[79:64], score_in[95:80], depth_in[103:96],
    // bound_in[105:104], zero fill
    input  logic [111:0] s_axis_tdata,
    // op[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // hit[0], move_out[16:1], score_out[32:17], depth_out[40:33],
    // bound_out[42:41], age_out[50:43], zero fill
    output logic [55:0]  m_axis_tdata
);
    logic    cmd_valid, cmd_ready;
    cmd_t    cmd;
    result_t res;

    bht_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .op         (s_axis_tuser),
        .lookup_key (s_axis_tdata[63:0]),
        .move_in    (s_axis_tdata[79:64]),
        .score_in   (s_axis_tdata[95:80]),
        .depth_in   (s_axis_tdata[103:96]),
        .bound_in   (s_axis_tdata[105:104]),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd)
    );

    bht_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {5'd0, res.age, res.bound, res.depth, res.score, res.move, res.hit};
endmodule

>>> hw/rtl/bht_front.sv
`timescale 1ns / 1ps
module bht_front
    import bht_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] op,
    input  logic [KEY_W-1:0] lookup_key,
    input  logic [15:0] move_in,
    input  logic [15:0] score_in,
    input  logic [7:0]  depth_in,
    input  logic [1:0]  bound_in,
    output logic       cmd_valid,
    input  logic       cmd_ready,
    output cmd_t       cmd
);
    // two entry queue
    cmd_t       q_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg].op    <= op_t'(op);
            q_reg[wp_reg].key   <= lookup_key;
            q_reg[wp_reg].index <= lookup_key[INDEX_BITS-1:0];
            q_reg[wp_reg].move  <= move_in;
            q_reg[wp_reg].score <= score_in;
            q_reg[wp_reg].depth <= depth_in;
            q_reg[wp_reg].bound <= bound_in;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count out of range");
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !in_ready)
        else $error("full queue accepted word");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != 2'd0)
        else $error("pop from empty queue");
endmodule

>>> hw/rtl/bht_back.sv
`timescale 1ns / 1ps
module bht_back
    import bht_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    output logic    cmd_ready,
    input  cmd_t    cmd,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);
    typedef enum logic [1:0] { S_CLR, S_IDLE, S_RD, S_OUT } state_t;

    // bucket memory, one row per bucket; a way with bound zero counts as empty, the clear sweep zeroes rows
    entry_t mem [BUCKETS][WAYS];
    entry_t row_reg [WAYS];

    state_t                state_reg;
    logic [INDEX_BITS:0]   clr_reg;
    cmd_t                  cmd_reg;
    logic [7:0]            age_reg;
    result_t               res_reg;

    logic                  do_write;
    logic [INDEX_BITS-1:0] wr_idx;
    logic [WAY_BITS-1:0]   wr_way;
    entry_t                wr_data;
    logic                  wr_all;

    // store victim choice and probe match
    logic                  found;
    logic [WAY_BITS-1:0]   pick, hit_way;
    logic                  hit_any;
    logic signed [PRIO_W-1:0] best, pr;
    logic [7:0]            diff;
    result_t               hit_res;

    always_comb
    begin
        found   = 1'b0;
        pick    = '0;
        best    = '0;
        hit_any = 1'b0;
        hit_way = '0;
        diff    = '0;
        pr      = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit_any && row_reg[w].key == cmd_reg.key && row_reg[w].pl.bound != 2'd0)
            begin
                hit_any = 1'b1;
                hit_way = WAY_BITS'(w);
            end
            if (!found)
            begin
                if (row_reg[w].pl.bound == 2'd0 || row_reg[w].key == cmd_reg.key)
                begin
                    found = 1'b1;
                    pick  = WAY_BITS'(w);
                end
                else
                begin
                    diff = age_reg - row_reg[w].pl.age;
                    pr   = $signed({{(PRIO_W-8){1'b0}}, row_reg[w].pl.depth})
                         - $signed({1'b0, diff, {AGE_PENALTY_LSH{1'b0}}});
                    if (w == 0 || pr < best)
                    begin
                        best = pr;
                        pick = WAY_BITS'(w);
                    end
                end
            end
        end
        hit_res = '0;
        if (hit_any)
        begin
            hit_res.hit   = 1'b1;
            hit_res.move  = row_reg[hit_way].pl.move;
            hit_res.score = row_reg[hit_way].pl.score;
            hit_res.depth = row_reg[hit_way].pl.depth;
            hit_res.bound = row_reg[hit_way].pl.bound;
            hit_res.age   = row_reg[hit_way].pl.age;
        end
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign res       = res_reg;

    always_comb
    begin
        do_write = 1'b0;
        wr_all   = 1'b0;
        wr_idx   = cmd_reg.index;
        wr_way   = pick;
        wr_data.key      = cmd_reg.key;
        wr_data.pl.move  = cmd_reg.move;
        wr_data.pl.score = cmd_reg.score;
        wr_data.pl.depth = cmd_reg.depth;
        wr_data.pl.bound = cmd_reg.bound;
        wr_data.pl.age   = age_reg;
        if (state_reg == S_CLR)
        begin
            do_write = 1'b1;
            wr_all   = 1'b1;
            wr_idx   = clr_reg[INDEX_BITS-1:0];
            wr_data  = '0;
        end
        else if (state_reg == S_RD && cmd_reg.op == OP_STORE)
        begin
            do_write = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                if (wr_all || wr_way == WAY_BITS'(w))
                begin
                    mem[wr_idx][w] <= wr_data;
                end
            end
        end
        if (cmd_valid && cmd_ready)
        begin
            row_reg <= mem[cmd.index];
            cmd_reg <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            age_reg   <= 8'd0;
            res_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_CLR:
                begin
                    if (clr_reg[INDEX_BITS-1:0] == {INDEX_BITS{1'b1}})
                    begin
                        clr_reg   <= '0;
                        state_reg <= (clr_reg[INDEX_BITS]) ? S_OUT : S_IDLE;
                    end
                    else
                    begin
                        clr_reg <= clr_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    // only a probe returns data, everything else answers zero
                    res_reg <= (cmd_reg.op == OP_PROBE) ? hit_res : '0;
                    case (cmd_reg.op)
                        OP_PROBE:
                        begin
                            state_reg <= S_OUT;
                        end
                        OP_AGE:
                        begin
                            age_reg   <= age_reg + 8'd1;
                            state_reg <= S_OUT;
                        end
                        OP_CLEAR:
                        begin
                            // top bit marks a sweep that owes a result
                            clr_reg   <= {1'b1, {INDEX_BITS{1'b0}}};
                            state_reg <= S_CLR;
                        end
                        default:
                        begin
                            state_reg <= S_OUT;
                        end
                    endcase
                end
                S_OUT:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_reg))
        else $error("result changed while stalled");
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.hit |-> res.bound == 2'd0 && res.depth == 8'd0)
        else $error("miss result not zero");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLR |-> !cmd_ready)
        else $error("command taken during clear");
endmodule
